/* sv/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// Types and codes shared by the positional list engine and its cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Request codes
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_POS   = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;
  localparam logic [2:0] OP_DEL_POS   = 3'd5;

  localparam int unsigned POS_W = 5;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned VAL_W = 32;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] removed_value;
    logic [LEN_W-1:0]        length;
  } rsp_t;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LEFT  = 2'd1,
    CELL_RIGHT = 2'd2,
    CELL_LOAD  = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       hit;
  } cell_ctrl_t;

endpackage

/* sv/ple_cell.sv */
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds a value, shifts from either neighbor or loads new data.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                             clk,
  input  ple_pkg::cell_ctrl_t              ctrl,
  input  logic signed [ple_pkg::VAL_W-1:0] left,
  input  logic signed [ple_pkg::VAL_W-1:0] right,
  input  logic signed [ple_pkg::VAL_W-1:0] load,
  output logic signed [ple_pkg::VAL_W-1:0] value,
  output logic signed [ple_pkg::VAL_W-1:0] tap
);

  logic signed [ple_pkg::VAL_W-1:0] value_next;

  always_comb begin
    case (ctrl.mode)
      ple_pkg::CELL_HOLD:  value_next = value;
      ple_pkg::CELL_LEFT:  value_next = left;
      ple_pkg::CELL_RIGHT: value_next = right;
      ple_pkg::CELL_LOAD:  value_next = load;
      default:             value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // drive the slot onto the read bus only when addressed
  assign tap = ctrl.hit ? value : '0;

endmodule

/* sv/positional_list_engine_top.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of up to CAPACITY signed values with insert/delete at the
// front, the back or any position, built as a shift chain of slot cells.
// ----------------------------------------------------------------------------
// Each accepted request item produces exactly one response item, registered
// and presented on rsp the cycle after acceptance. Every slot cell moves in
// the same cycle (hold, shift toward the back, shift toward the front, or
// load), so a new request item is taken every cycle while rsp is not
// stalled. The request side stalls only while a response sits in the
// output register and rsp_stall is high. A failed request (full list, empty
// list, position out of range, or an unused opcode) leaves the list
// untouched and reports ok = 0, removed_value = 0 and the current count.
// The length field is 5 bits wide, so counts above 31 wrap in that field.
// Slot contents come out of reset undefined; only slots below the count are
// ever read.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ple_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ple_pkg::rsp_t   rsp
);

  // count width, and a compare width wide enough for both count and position
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;

  logic [CNT_W-1:0] count;
  logic [CMP_W-1:0] count_w;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] target;
  logic [CMP_W-1:0] count_next_w;
  logic             accept;
  logic             is_ins;
  logic             is_del;
  logic             ins_ok;
  logic             del_ok;
  logic             do_ins;
  logic             do_del;
  logic signed [ple_pkg::VAL_W-1:0] removed;

  logic signed [ple_pkg::VAL_W-1:0] cell_val [CAPACITY];
  logic signed [ple_pkg::VAL_W-1:0] cell_tap [CAPACITY];
  ple_pkg::cell_ctrl_t              cell_ctrl [CAPACITY];

  // Accept whenever the output register is free or drains this cycle
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  assign count_w = CMP_W'(count);
  assign pos_w   = CMP_W'(req.position);

  // Decode the request into a target slot
  always_comb begin
    is_ins = 1'b0;
    is_del = 1'b0;
    target = '0;
    case (req.opcode)
      ple_pkg::OP_INS_FRONT: begin
        is_ins = 1'b1;
      end
      ple_pkg::OP_INS_BACK: begin
        is_ins = 1'b1;
        target = count_w;
      end
      ple_pkg::OP_INS_POS: begin
        is_ins = 1'b1;
        target = pos_w;
      end
      ple_pkg::OP_DEL_FRONT: begin
        is_del = 1'b1;
      end
      ple_pkg::OP_DEL_BACK: begin
        // an empty list fails below, so the wrap of count - 1 is harmless
        is_del = 1'b1;
        target = count_w - CMP_W'(1);
      end
      ple_pkg::OP_DEL_POS: begin
        is_del = 1'b1;
        target = pos_w;
      end
      default: begin
        // unused codes: no change, report failure
      end
    endcase
  end

  // Insert needs room and a position no further than the back; delete needs
  // a position below the count, which also rules out an empty list.
  assign ins_ok = is_ins && (count_w < CMP_W'(CAPACITY)) && (target <= count_w);
  assign del_ok = is_del && (target < count_w);
  assign do_ins = accept & ins_ok;
  assign do_del = accept & del_ok;

  // Shift chain: each cell takes its mode from where it sits against target
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].hit  = (CMP_W'(i) == target);
      cell_ctrl[i].mode = ple_pkg::CELL_HOLD;
      if (do_ins) begin
        if (CMP_W'(i) > target) begin
          cell_ctrl[i].mode = ple_pkg::CELL_LEFT;
        end else if (CMP_W'(i) == target) begin
          cell_ctrl[i].mode = ple_pkg::CELL_LOAD;
        end
      end else if (do_del) begin
        if (CMP_W'(i) >= target) begin
          cell_ctrl[i].mode = ple_pkg::CELL_RIGHT;
        end
      end
    end

    ple_cell u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl[i]),
      .left  ((i == 0) ? req.value : cell_val[(i == 0) ? 0 : i - 1]),
      .right ((i == CAPACITY - 1) ? req.value : cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .load  (req.value),
      .value (cell_val[i]),
      .tap   (cell_tap[i])
    );
  end

  // Gather the addressed slot; only one cell drives a nonzero tap
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | cell_tap[i];
    end
  end

  always_comb begin
    count_next_w = count_w;
    if (ins_ok) begin
      count_next_w = count_w + CMP_W'(1);
    end else if (del_ok) begin
      count_next_w = count_w - CMP_W'(1);
    end
  end

  // Advance the count on a successful request
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next_w[CNT_W-1:0];
    end
  end

  // Response register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.ok            <= ins_ok | del_ok;
      rsp.removed_value <= del_ok ? removed : '0;
      rsp.length        <= count_next_w[ple_pkg::LEN_W-1:0];
    end
  end

endmodule

/* sv/ple_checker.sv */
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks for the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ple_pkg::rsp_t rsp
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // every accepted request yields a response next cycle
  a_req_to_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted request gave no response");

  // request side stalls only behind a blocked response
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a blocked response");

  // a failed request never reports a removed value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.removed_value == '0)
    else $error("failed request reported a removed value");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (.*);

/* tb/list_mirror_pkg.sv */
// ----------------------------------------------------------------------------
// list_mirror_pkg
// Shadow copy of the positional list and the queue of responses it owes.
// ----------------------------------------------------------------------------
package list_mirror_pkg;
  import ple_pkg::*;

  // Opcodes the engine does not decode; they must come back rejected
  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;

  class list_mirror;
    int unsigned capacity;
    logic signed [VAL_W-1:0] elems[$];
    rsp_t due[$];
    int unsigned mismatches;
    int unsigned n_req, n_ins_ok, n_del_ok, n_rejected, n_at_full, n_on_empty;

    function new(int unsigned cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // Apply one accepted request item to the shadow list and queue its response
    function void take_request(req_t r);
      rsp_t want;
      int unsigned at;
      bit is_ins;
      bit is_del;
      want = '0;
      at = 0;
      is_ins = 1'b0;
      is_del = 1'b0;
      case (r.opcode)
        OP_INS_FRONT: is_ins = 1'b1;
        OP_INS_BACK: begin
          is_ins = 1'b1;
          at = elems.size();
        end
        OP_INS_POS: begin
          is_ins = 1'b1;
          at = r.position;
        end
        OP_DEL_FRONT: is_del = 1'b1;
        OP_DEL_BACK: begin
          is_del = 1'b1;
          at = (elems.size() == 0) ? 0 : elems.size() - 1;
        end
        OP_DEL_POS: begin
          is_del = 1'b1;
          at = r.position;
        end
        default: ;
      endcase
      if (is_ins) begin
        if (elems.size() >= capacity) begin
          n_at_full++;
        end else if (at <= elems.size()) begin
          elems.insert(at, r.value);
          want.ok = 1'b1;
          n_ins_ok++;
        end
      end else if (is_del) begin
        if (elems.size() == 0) begin
          n_on_empty++;
        end else if (at < elems.size()) begin
          want.removed_value = elems[at];
          elems.delete(at);
          want.ok = 1'b1;
          n_del_ok++;
        end
      end
      if (!want.ok) n_rejected++;
      want.length = LEN_W'(elems.size());
      due.push_back(want);
      n_req++;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    // Compare one accepted response item against the oldest owed response
    task match_response(rsp_t got);
      rsp_t want;
      if (due.size() == 0) begin
        report($sformatf("response with none owed (ok %b removed %0d length %0d)",
                         got.ok, got.removed_value, got.length));
        return;
      end
      want = due.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok got %b want %b", got.ok, want.ok));
      if (got.removed_value !== want.removed_value)
        report($sformatf("removed_value got %0d want %0d",
                         got.removed_value, want.removed_value));
      if (got.length !== want.length)
        report($sformatf("length got %0d want %0d", got.length, want.length));
    endtask
  endclass

endpackage

/* tb/tb_positional_list_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_positional_list_engine_top
// Self-checking bench for the positional list engine. A shadow list predicts
// every response; random insert/delete phases fill and drain the list while
// both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_top;
  import ple_pkg::*;
  import list_mirror_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned N_RANDOM     = 830;
  localparam int unsigned PHASE_LEN    = 40;
  localparam int unsigned QUIET_LIMIT  = 3000;  // well above the long hold-off
  localparam int unsigned PRESSURE_AT  = 300;
  localparam int unsigned PRESSURE_LEN = 400;
  localparam int unsigned POS_MAX      = 2**POS_W - 1;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req       = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  list_mirror  mirror;
  int unsigned n_accepted   = 0;
  int unsigned n_responses  = 0;
  int unsigned quiet_cycles = 0;
  bit          sender_dense = 1'b0;

  positional_list_engine_top #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Monitor: note accepted requests first, so a response arriving in the
  // same edge always finds its prediction queued. Also run the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        mirror.take_request(req);
        n_accepted++;
      end
      if (rsp_valid && !rsp_stall) begin
        mirror.match_response(rsp);
        n_responses++;
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("[positional_list_engine_top] ERROR");
        $finish;
      end
    end
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long pause
  function automatic int unsigned pick_gap(bit dense);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (dense || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_req(logic [2:0] op, int unsigned pos,
                                    logic signed [VAL_W-1:0] val);
    req_t r;
    r.opcode   = op;
    r.position = POS_W'(pos);
    r.value    = val;
    return r;
  endfunction

  // Build one random request; lean is the percent chance of an insert.
  // A small share is noise: unused opcodes and positions past the capacity.
  function automatic req_t random_req(int unsigned lean);
    req_t r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4)
      r.opcode = 3'($urandom_range(OP_UNUSED_A, OP_UNUSED_B));
    else if ($urandom_range(0, 99) < lean)
      r.opcode = 3'($urandom_range(OP_INS_FRONT, OP_INS_POS));
    else
      r.opcode = 3'($urandom_range(OP_DEL_FRONT, OP_DEL_POS));
    if ($urandom_range(0, 99) < 85)
      r.position = POS_W'($urandom_range(0, CAPACITY + 1));
    else
      r.position = POS_W'($urandom_range(0, POS_MAX));
    roll = $urandom_range(0, 99);
    case (roll % 10)
      0: r.value = (roll < 50) ? VAL_MAX : VAL_MIN;
      1: r.value = (roll < 50) ? '0 : '1;
      default: r.value = $urandom;
    endcase
    return r;
  endfunction

  // Offer one item after a random gap and hold it until it is accepted
  task automatic send_item(req_t r);
    int unsigned gap;
    gap = pick_gap(sender_dense);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Response side: random stall runs, clear stretches, and once a long
  // hold-off so the output register fills and the engine stalls its input.
  initial begin
    int unsigned roll;
    bit pressed;
    pressed = 1'b0;
    @(posedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      if (!pressed && n_accepted >= PRESSURE_AT) begin
        rsp_stall <= 1'b1;
        repeat (PRESSURE_LEN) @(posedge clk);
        pressed = 1'b1;
      end else if (roll < 50) begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else if (roll < 65) begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else if (roll < 95) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned lean;
    mirror = new(CAPACITY);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, out-of-range positions, extreme values,
    // append at the count, unused opcodes, then drain back to empty.
    send_item(make_req(OP_DEL_FRONT, 0, 0));
    send_item(make_req(OP_DEL_BACK, 0, 0));
    send_item(make_req(OP_DEL_POS, 0, 0));
    send_item(make_req(OP_INS_POS, 1, 5));         // past the end of an empty list
    send_item(make_req(OP_INS_POS, 0, VAL_MAX));
    send_item(make_req(OP_INS_FRONT, 0, VAL_MIN));
    send_item(make_req(OP_INS_BACK, 0, '1));
    send_item(make_req(OP_INS_POS, 3, '0));        // position equal to count appends
    send_item(make_req(OP_INS_POS, POS_MAX, 9));
    send_item(make_req(OP_UNUSED_A, 0, 1));
    send_item(make_req(OP_UNUSED_B, POS_MAX, VAL_MAX));
    send_item(make_req(OP_DEL_POS, 4, 0));         // position equal to count
    send_item(make_req(OP_DEL_POS, POS_MAX, 0));
    send_item(make_req(OP_DEL_POS, 1, 0));
    send_item(make_req(OP_DEL_BACK, 0, 0));
    send_item(make_req(OP_DEL_FRONT, 0, 0));
    send_item(make_req(OP_DEL_POS, 0, 0));

    // Random phases: insert-only first to hit the full list, then phases
    // that lean toward filling, churning or draining.
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0: lean = 85;
          1: lean = 50;
          default: lean = 15;
        endcase
        if (i == 0) lean = 100;
        sender_dense = ($urandom_range(0, 3) == 0);
      end
      send_item(random_req(lean));
    end
    req_valid <= 1'b0;

    // Drain: wait for every owed response, then keep the clock running before the summary
    while (mirror.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("ran %0d requests, checked %0d responses: %0d inserts and %0d deletes ok",
             mirror.n_req, n_responses, mirror.n_ins_ok, mirror.n_del_ok);
    $display("rejected %0d (%0d inserts on a full list, %0d deletes on an empty one)",
             mirror.n_rejected, mirror.n_at_full, mirror.n_on_empty);
    if (mirror.mismatches == 0) begin
      $display("[positional_list_engine_top] OK");
    end else begin
      $display("[positional_list_engine_top] ERROR");
    end
    $finish;
  end

endmodule
